// ===== rtl/pwc_pkg.sv =====
package pwc_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegLeft   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTop    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRight  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBottom = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     closes_polygon;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic                     final_vertex;
    logic                     all_clipped;
  } out_item_t;

  // work item held in the per-stage vertex queues of the back end
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     close;  // closing marker only, no vertex
  } vtx_t;

endpackage

// ===== rtl/polygon_window_clipper_unit.sv =====
// Sutherland-Hodgman clipper: vertices enter through a four-entry queue and are clipped
// against top, right, bottom and left in turn by one sequencer sharing one divider. Each
// window crossing is computed by the bit-serial divider. Results leave one clipped vertex
// late so the last can carry final_vertex; a polygon with nothing left gives one
// all_clipped result with zero coordinates. Register writes take effect at once and
// should be made between polygons.
module polygon_window_clipper_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pwc_pkg::in_item_t               item_i,
  input  logic                            push,
  output logic                            full,
  output pwc_pkg::out_item_t              item_o,
  output logic                            empty,
  input  logic                            pop,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pwc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pwc_pkg::CoordW-1:0]      cfg_data_i
);
  import pwc_pkg::*;

  in_item_t head;
  logic     head_valid, head_take;
  logic signed [CoordW-1:0] left_q, top_q, right_q, bottom_q;

  assign cfg_ready_o = 1'b1;

  // hold window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      top_q <= '0;
      right_q <= 16'sd32767;
      bottom_q <= 16'sd32767;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegLeft:   left_q <= cfg_data_i;
        RegTop:    top_q <= cfg_data_i;
        RegRight:  right_q <= cfg_data_i;
        RegBottom: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pwc_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .item_i, .push, .full,
    .head_o(head), .head_valid_o(head_valid), .head_take_i(head_take)
  );

  pwc_back u_back (
    .clk_i, .rst_ni,
    .head_i(head), .head_valid_i(head_valid), .head_take_o(head_take),
    .win_left_i(left_q), .win_top_i(top_q), .win_right_i(right_q), .win_bottom_i(bottom_q),
    .res_o(item_o), .empty, .pop
  );
endmodule

// ===== rtl/pwc_muldiv.sv =====
// Signed a*b/c truncated toward zero, restoring divide one quotient bit a cycle.
// |b| <= |c| on every use, so the quotient fits in the width of a.
module pwc_muldiv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [pwc_pkg::CoordW:0] a_i,
  input  logic signed [pwc_pkg::CoordW:0] b_i,
  input  logic signed [pwc_pkg::CoordW:0] c_i,
  output logic                            done_o,
  output logic signed [pwc_pkg::CoordW:0] q_o
);
  import pwc_pkg::*;

  localparam int unsigned MagW = CoordW + 1;
  localparam int unsigned ProdW = 2 * MagW;
  localparam int unsigned CntW = $clog2(ProdW + 2);

  typedef enum logic [1:0] {SIdle, SMul, SDiv, SDone} state_e;

  state_e               state_q;
  logic [ProdW-1:0]     num_q;
  logic [MagW-1:0]      rem_q;
  logic [MagW-1:0]      den_q;
  logic [ProdW-1:0]     quo_q;
  logic [CntW-1:0]      cnt_q;
  logic                 neg_q;
  logic [MagW-1:0]      ma, mb, mc;
  logic [MagW:0]        rem_sh;
  logic signed [ProdW:0] res;

  assign ma = a_i[MagW-1] ? MagW'(-a_i) : MagW'(a_i);
  assign mb = b_i[MagW-1] ? MagW'(-b_i) : MagW'(b_i);
  assign mc = c_i[MagW-1] ? MagW'(-c_i) : MagW'(c_i);
  assign rem_sh = {rem_q, num_q[ProdW-1]};
  assign res = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign q_o = res[MagW-1:0];
  assign done_o = (state_q == SDone);

  // multiply once, then shift out one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
    end else begin
      unique case (state_q)
        SIdle: if (start_i) begin
          state_q <= SMul;
          neg_q <= (a_i[MagW-1] ^ b_i[MagW-1] ^ c_i[MagW-1]);
          num_q <= ProdW'(ma) * ProdW'(mb);
          den_q <= mc;
          rem_q <= '0;
          quo_q <= '0;
        end
        SMul: begin
          if (den_q == '0) begin
            state_q <= SDone;
          end else begin
            state_q <= SDiv;
            cnt_q <= CntW'(ProdW);
          end
        end
        SDiv: begin
          num_q <= {num_q[ProdW-2:0], 1'b0};
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= MagW'(rem_sh - {1'b0, den_q});
            quo_q <= {quo_q[ProdW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[MagW-1:0];
            quo_q <= {quo_q[ProdW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) state_q <= SDone;
        end
        SDone: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== rtl/pwc_front.sv =====
// Accept incoming vertices and queue them for the clipping back end.
module pwc_front #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pwc_pkg::in_item_t item_i,
  input  logic              push,
  output logic              full,
  output pwc_pkg::in_item_t head_o,
  output logic              head_valid_o,
  input  logic              head_take_i
);
  import pwc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t         mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full = (cnt_q == (PtrW+1)'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o = mem_q[rd_q];
  assign do_wr = push && !full;
  assign do_rd = head_take_i && head_valid_o;

  // store item
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_q] <= item_i;
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + PtrW'(1);
      if (do_rd) rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end
  end
endmodule

// ===== rtl/pwc_back.sv =====
// Run the four clip stages over one vertex with per-stage work queues and a shared divider.
module pwc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pwc_pkg::in_item_t  head_i,
  input  logic               head_valid_i,
  output logic               head_take_o,
  input  logic signed [pwc_pkg::CoordW-1:0] win_left_i,
  input  logic signed [pwc_pkg::CoordW-1:0] win_top_i,
  input  logic signed [pwc_pkg::CoordW-1:0] win_right_i,
  input  logic signed [pwc_pkg::CoordW-1:0] win_bottom_i,
  output pwc_pkg::out_item_t res_o,
  output logic               empty,
  input  logic               pop
);
  import pwc_pkg::*;

  // pending work per stage: vertex queue of up to 4 entries (each stage adds <=2 per input,
  // plus a close marker)
  localparam int unsigned QD = 4;
  localparam int unsigned W = CoordW + 1;

  typedef enum logic [2:0] {SIdle, SPick, SEdge, SDiv, SPush, SOut} state_e;

  state_e state_q;
  vtx_t   q_q [4][QD];
  logic [2:0] qn_q [4];
  logic signed [CoordW-1:0] fx_q [4], fy_q [4], px_q [4], py_q [4];
  logic [3:0] seen_q;
  logic [1:0] st_q;
  vtx_t   cur_q;
  logic   edge_q;       // handling an edge (p -> target)
  logic   emit_q_q;     // emit target after crossing
  logic signed [CoordW-1:0] tx_q, ty_q;
  logic   fin_q;        // close marker must follow
  logic   hold_v_q;
  logic signed [CoordW-1:0] hx_q, hy_q;
  out_item_t out_q;
  logic   out_v_q;
  logic   div_start;
  logic   div_done;
  logic signed [W-1:0] div_a, div_b, div_c, div_q;
  logic   pin, tin;
  logic signed [CoordW-1:0] px, py, bnd;
  logic   any_work;
  logic [1:0] pick;
  logic signed [W:0] sum;

  pwc_muldiv u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .a_i(div_a), .b_i(div_b), .c_i(div_c),
    .done_o(div_done), .q_o(div_q)
  );

  assign px = px_q[st_q];
  assign py = py_q[st_q];

  // inside test, bound and divider operands of the current stage
  always_comb begin
    case (st_q)
      2'd0: begin pin = (py >= win_top_i);    tin = (ty_q >= win_top_i);    bnd = win_top_i; end
      2'd1: begin pin = (px <= win_right_i);  tin = (tx_q <= win_right_i);  bnd = win_right_i; end
      2'd2: begin pin = (py <= win_bottom_i); tin = (ty_q <= win_bottom_i); bnd = win_bottom_i; end
      default: begin pin = (px >= win_left_i); tin = (tx_q >= win_left_i); bnd = win_left_i; end
    endcase
    if (st_q[0] == 1'b0) begin
      div_a = W'(tx_q) - W'(px);
      div_b = W'(bnd) - W'(py);
      div_c = W'(ty_q) - W'(py);
    end else begin
      div_a = W'(ty_q) - W'(py);
      div_b = W'(bnd) - W'(px);
      div_c = W'(tx_q) - W'(px);
    end
  end

  assign sum = (st_q[0] == 1'b0) ? ((W+1)'(px) + (W+1)'(div_q)) : ((W+1)'(py) + (W+1)'(div_q));

  // deepest stage with pending work goes first
  always_comb begin
    any_work = 1'b0;
    pick = 2'd0;
    for (int s = 0; s < 4; s++) begin
      if (qn_q[s] != 3'd0) begin
        any_work = 1'b1;
        pick = 2'(s);
      end
    end
  end

  assign div_start = (state_q == SEdge) && (pin != tin);
  assign head_take_o = (state_q == SIdle) && head_valid_i;
  assign empty = !out_v_q;
  assign res_o = out_q;

  // sequence stages; a stage output goes to the next stage's queue or the output hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      seen_q <= '0;
      hold_v_q <= 1'b0;
      out_v_q <= 1'b0;
      for (int s = 0; s < 4; s++) begin
        qn_q[s] <= '0;
        fx_q[s] <= '0; fy_q[s] <= '0; px_q[s] <= '0; py_q[s] <= '0;
      end
      st_q <= '0;
    end else begin
      if (out_v_q && pop) out_v_q <= 1'b0;
      unique case (state_q)
        SIdle: if (head_valid_i) begin
          q_q[0][0] <= '{x: head_i.vertex_x, y: head_i.vertex_y, close: 1'b0};
          if (head_i.closes_polygon) begin
            q_q[0][1] <= '{x: '0, y: '0, close: 1'b1};
            qn_q[0] <= 3'd2;
          end else begin
            qn_q[0] <= 3'd1;
          end
          state_q <= SPick;
        end
        SPick: begin
          if (!any_work) begin
            state_q <= SIdle;
          end else begin
            st_q <= pick;
            cur_q <= q_q[pick][0];
            for (int k = 0; k < QD - 1; k++) q_q[pick][k] <= q_q[pick][k+1];
            qn_q[pick] <= qn_q[pick] - 3'd1;
            state_q <= SPush;
            edge_q <= 1'b0;
            fin_q <= 1'b0;
            if (q_q[pick][0].close) begin
              if (seen_q[pick]) begin
                tx_q <= fx_q[pick]; ty_q <= fy_q[pick];
                edge_q <= 1'b1;
                emit_q_q <= 1'b0;
                seen_q[pick] <= 1'b0;
                state_q <= SEdge;
              end
              fin_q <= 1'b1;
            end else if (!seen_q[pick]) begin
              seen_q[pick] <= 1'b1;
              fx_q[pick] <= q_q[pick][0].x; fy_q[pick] <= q_q[pick][0].y;
              px_q[pick] <= q_q[pick][0].x; py_q[pick] <= q_q[pick][0].y;
              state_q <= SPick;
            end else begin
              tx_q <= q_q[pick][0].x; ty_q <= q_q[pick][0].y;
              edge_q <= 1'b1;
              emit_q_q <= 1'b1;
              state_q <= SEdge;
            end
          end
        end
        SEdge: begin
          emit_q_q <= tin;
          state_q <= (pin != tin) ? SDiv : SPush;
        end
        SDiv: if (div_done) begin
          if (st_q[0] == 1'b0) begin
            tx_q <= sum[CoordW-1:0];
            ty_q <= bnd;
          end else begin
            tx_q <= bnd;
            ty_q <= sum[CoordW-1:0];
          end
          // emit crossing then revisit for target
          state_q <= SOut;
        end
        SOut: begin
          // crossing point in tx/ty; restore target afterwards
          if (!(out_v_q && !pop) || st_q != 2'd3 || !hold_v_q) begin
            if (st_q == 2'd3) begin
              if (hold_v_q) begin
                out_q <= '{out_x: hx_q, out_y: hy_q, final_vertex: 1'b0, all_clipped: 1'b0};
                out_v_q <= 1'b1;
              end
              hx_q <= tx_q; hy_q <= ty_q; hold_v_q <= 1'b1;
            end else begin
              q_q[st_q+2'd1][qn_q[st_q+2'd1][1:0]] <= '{x: tx_q, y: ty_q, close: 1'b0};
              qn_q[st_q+2'd1] <= qn_q[st_q+2'd1] + 3'd1;
            end
            if (cur_q.close) begin tx_q <= fx_q[st_q]; ty_q <= fy_q[st_q]; end
            else begin tx_q <= cur_q.x; ty_q <= cur_q.y; end
            state_q <= SPush;
          end
        end
        SPush: begin
          if (!(out_v_q && !pop) || st_q != 2'd3 || !(hold_v_q || fin_q)) begin
            if (edge_q && emit_q_q) begin
              if (!cur_q.close) begin px_q[st_q] <= cur_q.x; py_q[st_q] <= cur_q.y; end
              if (st_q == 2'd3) begin
                if (hold_v_q) begin
                  out_q <= '{out_x: hx_q, out_y: hy_q, final_vertex: 1'b0, all_clipped: 1'b0};
                  out_v_q <= 1'b1;
                end
                hx_q <= tx_q; hy_q <= ty_q; hold_v_q <= 1'b1;
                edge_q <= 1'b0;
                state_q <= fin_q ? SPush : SPick;
              end else begin
                q_q[st_q+2'd1][qn_q[st_q+2'd1][1:0]] <= '{x: tx_q, y: ty_q, close: 1'b0};
                qn_q[st_q+2'd1] <= qn_q[st_q+2'd1] + 3'd1;
                edge_q <= 1'b0;
                state_q <= fin_q ? SPush : SPick;
              end
            end else begin
              if (!cur_q.close) begin px_q[st_q] <= cur_q.x; py_q[st_q] <= cur_q.y; end
              if (fin_q) begin
                if (st_q == 2'd3) begin
                  out_q <= hold_v_q
                    ? '{out_x: hx_q, out_y: hy_q, final_vertex: 1'b1, all_clipped: 1'b0}
                    : '{out_x: '0, out_y: '0, final_vertex: 1'b1, all_clipped: 1'b1};
                  out_v_q <= 1'b1;
                  hold_v_q <= 1'b0;
                end else begin
                  q_q[st_q+2'd1][qn_q[st_q+2'd1][1:0]] <= '{x: '0, y: '0, close: 1'b1};
                  qn_q[st_q+2'd1] <= qn_q[st_q+2'd1] + 3'd1;
                end
              end
              edge_q <= 1'b0;
              fin_q <= 1'b0;
              state_q <= SPick;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== verif/pwc_checker.sv =====
module pwc_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pwc_pkg::in_item_t           item_i,
  input  logic                        push,
  input  logic                        full,
  input  pwc_pkg::out_item_t          item_o,
  input  logic                        empty,
  input  logic                        pop,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [pwc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pwc_pkg::CoordW-1:0]  cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          results_o,
  output int                          clipped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pwc_pkg::*;

  localparam int Stages = 4;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  // window and per-stage vertex memory
  longint win_left, win_top, win_right, win_bottom;
  point_t first_pt [Stages];
  point_t prev_pt  [Stages];
  bit     have_first [Stages];
  point_t held_pt;
  bit     held_valid;

  out_item_t clipped_results [$];

  assign pending_o = clipped_results.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic bit is_inside(int s, point_t v);
    case (s)
      0: return v.y >= win_top;
      1: return v.x <= win_right;
      2: return v.y <= win_bottom;
      default: return v.x >= win_left;
    endcase
  endfunction

  // crossing with the stage's window edge, quotient truncated toward zero
  function automatic point_t edge_crossing(int s, point_t p, point_t q);
    point_t r;
    longint bound, den;
    if (s == 0 || s == 2) begin
      bound = (s == 0) ? win_top : win_bottom;
      den = q.y - p.y;
      r.x = p.x + ((den == 0) ? 0 : ((q.x - p.x) * (bound - p.y)) / den);
      r.y = bound;
    end else begin
      bound = (s == 1) ? win_right : win_left;
      den = q.x - p.x;
      r.x = bound;
      r.y = p.y + ((den == 0) ? 0 : ((q.y - p.y) * (bound - p.x)) / den);
    end
    return r;
  endfunction

  function automatic void clip_segment(int s, point_t p, point_t q, ref point_t dst[$]);
    bit p_in, q_in;
    p_in = is_inside(s, p);
    q_in = is_inside(s, q);
    if (p_in != q_in) dst.insert(dst.size(), edge_crossing(s, p, q));
    if (q_in) dst.insert(dst.size(), q);
  endfunction

  function automatic void add_result(point_t v, bit last, bit none_left);
    out_item_t r;
    r.out_x = v.x[CoordW-1:0];
    r.out_y = v.y[CoordW-1:0];
    r.final_vertex = last;
    r.all_clipped = none_left;
    clipped_results.insert(clipped_results.size(), r);
  endfunction

  // run one vertex through the four stages and the output hold
  function automatic void clip_vertex(in_item_t it);
    point_t cur [$];
    point_t nxt [$];
    point_t v;
    v.x = longint'(it.vertex_x);
    v.y = longint'(it.vertex_y);
    cur.insert(0, v);
    for (int s = 0; s < Stages; s++) begin
      nxt.delete();
      foreach (cur[i]) begin
        if (!have_first[s]) begin
          have_first[s] = 1'b1;
          first_pt[s] = cur[i];
        end else begin
          clip_segment(s, prev_pt[s], cur[i], nxt);
        end
        prev_pt[s] = cur[i];
      end
      if (it.closes_polygon && have_first[s]) begin
        clip_segment(s, prev_pt[s], first_pt[s], nxt);
        have_first[s] = 1'b0;
      end
      cur = nxt;
    end
    foreach (cur[i]) begin
      if (held_valid) add_result(held_pt, 1'b0, 1'b0);
      held_pt = cur[i];
      held_valid = 1'b1;
    end
    if (it.closes_polygon) begin
      if (held_valid) begin
        add_result(held_pt, 1'b1, 1'b0);
      end else begin
        v.x = 0;
        v.y = 0;
        add_result(v, 1'b1, 1'b1);
      end
      held_valid = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      win_left = 0;
      win_top = 0;
      win_right = 32767;
      win_bottom = 32767;
      for (int s = 0; s < Stages; s++) begin
        first_pt[s] = '{0, 0};
        prev_pt[s] = '{0, 0};
        have_first[s] = 1'b0;
      end
      held_pt = '{0, 0};
      held_valid = 1'b0;
      fail_count_o = 0;
      results_o = 0;
      clipped_o = 0;
    end else begin
      // compare the result taken at this edge
      if (pop && !empty) begin
        results_o++;
        if (item_o.all_clipped) clipped_o++;
        if (clipped_results.size() == 0) begin
          report_mismatch("result count", results_o, results_o - 1);
        end else begin
          want = clipped_results.pop_front();
          if (item_o.out_x !== want.out_x)
            report_mismatch("out_x", item_o.out_x, want.out_x);
          if (item_o.out_y !== want.out_y)
            report_mismatch("out_y", item_o.out_y, want.out_y);
          if (item_o.final_vertex !== want.final_vertex)
            report_mismatch("final_vertex", item_o.final_vertex, want.final_vertex);
          if (item_o.all_clipped !== want.all_clipped)
            report_mismatch("all_clipped", item_o.all_clipped, want.all_clipped);
        end
      end
      if (push && !full) clip_vertex(item_i);
      // track register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegLeft:   win_left   = longint'($signed(cfg_data_i));
          RegTop:    win_top    = longint'($signed(cfg_data_i));
          RegRight:  win_right  = longint'($signed(cfg_data_i));
          RegBottom: win_bottom = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwc_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  in_item_t item_i = '0;
  logic push = 1'b0;
  logic full;
  out_item_t item_o;
  logic empty;
  logic pop = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = RegLeft;
  logic [CoordW-1:0] cfg_data_i = '0;

  int fail_count, pending, results, clipped;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int cycle_count = 0;
  int vertices_sent = 0;
  int polygons_sent = 0;
  int win_l = 0, win_t = 0, win_r = 32767, win_b = 32767;

  always #10 clk_i = ~clk_i;

  polygon_window_clipper_unit i_dut (
    .clk_i, .rst_ni, .item_i, .push, .full, .item_o, .empty, .pop,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  pwc_checker i_checker (
    .clk_i, .rst_ni, .item_i, .push, .full, .item_o, .empty, .pop,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .clipped_o(clipped)
  );

  // stall the result side at random
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // hard stop on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // drive one write; the caller drops valid after the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CoordW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_window(input int l, input int t, input int r, input int b);
    win_l = l; win_t = t; win_r = r; win_b = b;
    write_reg(RegLeft, l);
    write_reg(RegTop, t);
    write_reg(RegRight, r);
    write_reg(RegBottom, b);
    cfg_valid_i <= 1'b0;
  endtask

  // hold off until every result is in and the block has settled
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_vertex(input int x, input int y, input bit last);
    in_item_t it;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    it.vertex_x = x[CoordW-1:0];
    it.vertex_y = y[CoordW-1:0];
    it.closes_polygon = last;
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    vertices_sent++;
    if (last) polygons_sent++;
  endtask

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // coordinate near the window span, or anywhere
  function automatic int pick_coord(int lo, int hi);
    longint a, b, span;
    if ($urandom_range(5) == 0) return $signed(16'($urandom));
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = b - a + 8;
    a = a - span / 2;
    b = b + span / 2;
    if (b - a > 65535) return $signed(16'($urandom));
    return clamp16(a + longint'($urandom_range(int'(b - a))));
  endfunction

  task automatic send_random_polygon();
    int n;
    n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
    for (int i = 0; i < n; i++)
      send_vertex(pick_coord(win_l, win_r), pick_coord(win_t, win_b), i == n - 1);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int start;
    send_idle_pct = idle;
    pop_stall_pct = stall;
    start = vertices_sent;
    while (vertices_sent - start < count) send_random_polygon();
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default window, extremes and special cases
    send_vertex(100, 100, 1'b1);                 // lone point inside
    send_vertex(-5, 100, 1'b1);                  // lone point outside
    send_vertex(-32768, -32768, 1'b0);           // wholly outside
    send_vertex(-1, -32768, 1'b0);
    send_vertex(-1, -1, 1'b1);
    send_vertex(-32768, -32768, 1'b0);           // corner to corner, crosses top and left
    send_vertex(32767, -32768, 1'b0);
    send_vertex(32767, 32767, 1'b0);
    send_vertex(-32768, 32767, 1'b1);
    drain();

    set_window(-100, -50, 200, 150);
    send_vertex(0, 0, 1'b0);                     // wholly inside
    send_vertex(50, 0, 1'b0);
    send_vertex(50, 50, 1'b1);
    send_vertex(50, -300, 1'b0);                 // crosses every edge
    send_vertex(400, 50, 1'b0);
    send_vertex(50, 400, 1'b0);
    send_vertex(-300, 50, 1'b1);
    drain();

    // inverted window
    set_window(100, 100, -100, -100);
    send_vertex(0, 0, 1'b0);
    send_vertex(200, 0, 1'b0);
    send_vertex(0, 200, 1'b1);
    drain();

    // random polygons under several windows and flow patterns
    set_window(-32768, -32768, 32767, 32767);
    run_phase(0, 0, 55);
    set_window(-1000, -800, 1200, 900);
    run_phase(58, 0, 55);
    set_window(-20, -20, 20, 20);
    run_phase(0, 58, 55);
    set_window(-5000, -3000, 32767, 4000);
    run_phase(35, 35, 55);

    $display("%0d polygons, %0d vertices sent; %0d results, %0d wholly clipped",
             polygons_sent, vertices_sent, results, clipped);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pwc_pkg.sv
rtl/pwc_muldiv.sv
rtl/pwc_front.sv
rtl/pwc_back.sv
rtl/polygon_window_clipper_unit.sv
verif/pwc_checker.sv
verif/tb.sv
